@@ src/salhc_pkg.sv @@
// Shared types and constants for the set-associative LRU tag checker.
// No dependencies; salhc_way_cmp and the core use it by scoped name.
package salhc_pkg;

    localparam int ADDR_IN_W = 32;          // word address width
    localparam int TAG_W     = 32;          // stored tag width
    localparam int CFG_W     = 4;           // configuration register width
    localparam int CFG_IDX_W = 1;           // configuration index width
    localparam int IDX_W     = 15;          // widest masked set index (4-bit field)
    localparam int WORD_SHIFT = 2;          // byte-to-word offset in line_log2

    localparam int DEF_SETS = 256;
    localparam int DEF_WAYS = 8;

    localparam logic [CFG_W-1:0] LINE_LOG2_RESET      = 4'd4;
    localparam logic [CFG_W-1:0] SET_INDEX_BITS_RESET = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_LOG2      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SET_INDEX_BITS = 1'b1;

    // flags from the shared way compare unit
    typedef struct packed {
        logic match;      // valid way with matching tag
        logic rank_zero;  // way is least recently used
        logic above;      // rank above the reference rank
    } cmp_flags_t;

endpackage

@@ src/salhc_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module salhc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/salhc_way_cmp.sv @@
// Shared compare unit: checks one way entry against the lookup tag and a rank.
// Depends on salhc_pkg for the tag width and the flag struct.
module salhc_way_cmp #(
    parameter int WAYS = salhc_pkg::DEF_WAYS
) (
    input  logic [salhc_pkg::TAG_W-1:0]           entry_tag,
    input  logic                                  entry_valid,
    input  logic [(WAYS > 1 ? $clog2(WAYS) : 1)-1:0] entry_rank,
    input  logic [salhc_pkg::TAG_W-1:0]           key_tag,
    input  logic [(WAYS > 1 ? $clog2(WAYS) : 1)-1:0] ref_rank,
    output salhc_pkg::cmp_flags_t                 flags
);

    always_comb
    begin
        flags.match     = entry_valid && (entry_tag == key_tag);
        flags.rank_zero = (entry_rank == '0);
        flags.above     = (entry_rank > ref_rank);
    end

endmodule

@@ src/set_assoc_lru_hit_check_core.sv @@
// Set-associative tag store with true LRU replacement: one hit/miss result per address.
// Depends on salhc_pkg, salhc_ram and salhc_way_cmp.
//
// Each accepted word address yields one hit flag. in_stall stays high from its transfer
// until that flag is loaded, and a finished result waits in the output register while the
// next address is taken, so a new address is taken only after the last one is through.
// Each address passes through a set-number reduction modulo SETS by reciprocal
// multiplication (quotient, then remainder), a step for the set base, then two passes
// over the ways of the set through the single read port and single write port of the tag
// RAM with one shared compare unit: a scan pass that finds the hit or the LRU victim, and
// an update pass that rewrites the ranks and, on a miss, the refilled tag; a last step
// loads the output register. A stalled output holds the block in its last step. After
// reset a clearing pass writes every entry (tag zero, invalid, rank equal to way index)
// while in_stall is held high; configuration writes are taken at any time and cfg_ready
// is always high.
module set_assoc_lru_hit_check_core #(
    parameter int SETS = salhc_pkg::DEF_SETS,
    parameter int WAYS = salhc_pkg::DEF_WAYS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [salhc_pkg::ADDR_IN_W-1:0]    word_address,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               hit,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [salhc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [salhc_pkg::CFG_W-1:0]        cfg_data
);

    localparam int ENTRIES = SETS * WAYS;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int ENT_W   = salhc_pkg::TAG_W + 1 + RANK_W;

    // reciprocal of SETS, exact for every index below 2**IDX_W
    localparam int LOG_SETS = $clog2(SETS);
    localparam int RECIP_W  = salhc_pkg::IDX_W + 1;
    localparam int RECIP_K  = salhc_pkg::IDX_W + LOG_SETS;
    localparam int PROD_W   = salhc_pkg::IDX_W + RECIP_W;

    localparam logic [RANK_W-1:0] LAST_WAY  = RANK_W'(WAYS - 1);
    localparam logic [ADDR_W-1:0] LAST_ENT  = ADDR_W'(ENTRIES - 1);
    localparam logic [SET_W:0]    SETS_EXT  = (SET_W + 1)'(SETS);
    localparam logic [RECIP_W-1:0] RECIP    =
        RECIP_W'(((longint'(1) << RECIP_K) + longint'(SETS) - 1) / longint'(SETS));
    localparam logic [salhc_pkg::IDX_W-1:0] SETS_IDX = salhc_pkg::IDX_W'(SETS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_REM,
        ST_BASE,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } state_t;

    state_t                          state_reg;
    logic [salhc_pkg::CFG_W-1:0]     line_log2_reg;
    logic [salhc_pkg::CFG_W-1:0]     set_index_bits_reg;

    logic [ADDR_W-1:0]               clr_idx_reg;
    logic [RANK_W-1:0]               clr_way_reg;
    logic [salhc_pkg::TAG_W-1:0]     tag_reg;
    logic [salhc_pkg::IDX_W-1:0]     idx_reg;
    logic [salhc_pkg::IDX_W-1:0]     quot_reg;
    logic [SET_W-1:0]                set_reg;
    logic [ADDR_W-1:0]               base_reg;
    logic [RANK_W-1:0]               iss_way_reg;
    logic                            iss_done_reg;
    logic                            rd_pend_reg;
    logic [RANK_W-1:0]               rd_way_reg;
    logic                            hit_found_reg;
    logic [RANK_W-1:0]               hit_way_reg;
    logic [RANK_W-1:0]               hit_rank_reg;
    logic                            victim_found_reg;
    logic [RANK_W-1:0]               victim_way_reg;
    logic                            out_valid_reg;
    logic                            hit_reg;

    // address decode at the input transfer
    logic [salhc_pkg::CFG_W-1:0]     shamt;
    logic [salhc_pkg::ADDR_IN_W-1:0] true_addr;
    logic [salhc_pkg::ADDR_IN_W-1:0] index_mask;

    // modulo-SETS reduction: quotient by reciprocal, then remainder
    logic [PROD_W-1:0]               recip_prod;
    logic [salhc_pkg::IDX_W-1:0]     quot_next;
    logic [salhc_pkg::IDX_W-1:0]     rem_val;

    // RAM ports
    logic                            ram_we;
    logic [ADDR_W-1:0]               ram_waddr;
    logic [ENT_W-1:0]                ram_wdata;
    logic                            ram_re;
    logic [ADDR_W-1:0]               ram_raddr;
    logic [ENT_W-1:0]                ram_rdata;

    logic [salhc_pkg::TAG_W-1:0]     ent_tag;
    logic                            ent_valid;
    logic [RANK_W-1:0]               ent_rank;
    logic [RANK_W-1:0]               target_way;
    logic [RANK_W-1:0]               ref_rank;
    salhc_pkg::cmp_flags_t           flags;

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;

    always_comb
    begin
        shamt = (line_log2_reg >= salhc_pkg::CFG_W'(salhc_pkg::WORD_SHIFT))
              ? line_log2_reg - salhc_pkg::CFG_W'(salhc_pkg::WORD_SHIFT) : '0;
        true_addr  = word_address >> shamt;
        index_mask = ~({salhc_pkg::ADDR_IN_W{1'b1}} << set_index_bits_reg);
    end

    always_comb
    begin
        recip_prod = PROD_W'(idx_reg) * PROD_W'(RECIP);
        quot_next  = salhc_pkg::IDX_W'(recip_prod >> RECIP_K);
        rem_val    = idx_reg - quot_reg * SETS_IDX;
    end

    assign {ent_tag, ent_valid, ent_rank} = ram_rdata;
    assign target_way = hit_found_reg ? hit_way_reg : victim_way_reg;
    assign ref_rank   = hit_found_reg ? hit_rank_reg : '0;

    salhc_way_cmp #(
        .WAYS (WAYS)
    ) u_cmp (
        .entry_tag   (ent_tag),
        .entry_valid (ent_valid),
        .entry_rank  (ent_rank),
        .key_tag     (tag_reg),
        .ref_rank    (ref_rank),
        .flags       (flags)
    );

    always_comb
    begin
        ram_re    = ((state_reg == ST_SCAN) || (state_reg == ST_UPDATE)) && !iss_done_reg;
        ram_raddr = base_reg + ADDR_W'(iss_way_reg);
        ram_we    = 1'b0;
        ram_waddr = base_reg + ADDR_W'(rd_way_reg);
        ram_wdata = {tag_reg, 1'b1, LAST_WAY};
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_idx_reg;
            ram_wdata = {{salhc_pkg::TAG_W{1'b0}}, 1'b0, clr_way_reg};
        end
        else if ((state_reg == ST_UPDATE) && rd_pend_reg)
        begin
            if (rd_way_reg == target_way)
            begin
                // touched way: refill tag (same tag on a hit), valid, most recent
                ram_we = 1'b1;
            end
            else if (flags.above)
            begin
                ram_we    = 1'b1;
                ram_wdata = {ent_tag, ent_valid, ent_rank - RANK_W'(1)};
            end
        end
    end

    salhc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_CLEAR;
            line_log2_reg      <= salhc_pkg::LINE_LOG2_RESET;
            set_index_bits_reg <= salhc_pkg::SET_INDEX_BITS_RESET;
            clr_idx_reg        <= '0;
            clr_way_reg        <= '0;
            iss_way_reg        <= '0;
            iss_done_reg       <= 1'b0;
            rd_pend_reg        <= 1'b0;
            hit_found_reg      <= 1'b0;
            victim_found_reg   <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    salhc_pkg::REG_LINE_LOG2:      line_log2_reg      <= cfg_data;
                    salhc_pkg::REG_SET_INDEX_BITS: set_index_bits_reg <= cfg_data;
                    default: ;
                endcase
            end

            // the done step reloads the register itself
            if (out_valid_reg && !out_stall && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            // read issue shared by both passes over the ways
            if ((state_reg == ST_SCAN) || (state_reg == ST_UPDATE))
            begin
                rd_pend_reg <= !iss_done_reg;
                rd_way_reg  <= iss_way_reg;
                if (!iss_done_reg)
                begin
                    if (iss_way_reg == LAST_WAY)
                    begin
                        iss_done_reg <= 1'b1;
                    end
                    else
                    begin
                        iss_way_reg <= iss_way_reg + RANK_W'(1);
                    end
                end
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + ADDR_W'(1);
                    clr_way_reg <= (clr_way_reg == LAST_WAY) ? '0 : clr_way_reg + RANK_W'(1);
                    if (clr_idx_reg == LAST_ENT)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        tag_reg   <= true_addr >> set_index_bits_reg;
                        idx_reg   <= true_addr[salhc_pkg::IDX_W-1:0]
                                   & index_mask[salhc_pkg::IDX_W-1:0];
                        state_reg <= ST_MOD;
                    end
                end
                ST_MOD:
                begin
                    quot_reg  <= quot_next;
                    state_reg <= ST_REM;
                end
                ST_REM:
                begin
                    set_reg   <= SET_W'(rem_val);
                    state_reg <= ST_BASE;
                end
                ST_BASE:
                begin
                    base_reg         <= ADDR_W'(set_reg) * ADDR_W'(WAYS);
                    iss_way_reg      <= '0;
                    iss_done_reg     <= 1'b0;
                    rd_pend_reg      <= 1'b0;
                    hit_found_reg    <= 1'b0;
                    victim_found_reg <= 1'b0;
                    state_reg        <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (rd_pend_reg)
                    begin
                        // first matching way wins, like the first LRU way
                        if (!hit_found_reg && flags.match)
                        begin
                            hit_found_reg <= 1'b1;
                            hit_way_reg   <= rd_way_reg;
                            hit_rank_reg  <= ent_rank;
                        end
                        if (!victim_found_reg && flags.rank_zero)
                        begin
                            victim_found_reg <= 1'b1;
                            victim_way_reg   <= rd_way_reg;
                        end
                        if (rd_way_reg == LAST_WAY)
                        begin
                            iss_way_reg  <= '0;
                            iss_done_reg <= 1'b0;
                            state_reg    <= ST_UPDATE;
                        end
                    end
                end
                ST_UPDATE:
                begin
                    if (rd_pend_reg && (rd_way_reg == LAST_WAY))
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        hit_reg       <= hit_found_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // a result appears only at the end of an item's sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done step");

    // the tag RAM is written only by the clearing pass or the update pass
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == ST_CLEAR) || (state_reg == ST_UPDATE)))
        else $error("tag RAM write outside clear or update");

    // ranks stay a permutation, so a miss always finds an LRU way
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |-> (hit_found_reg || victim_found_reg))
        else $error("scan found neither a hit nor an LRU way");

    // the reduced set number stays inside the cache
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BASE) |-> (SET_W + 1)'(set_reg) < SETS_EXT)
        else $error("set number out of range");

endmodule
